// ===== rtl/btpc_pkg.sv =====
package btpc_pkg;

  // input item: sample kind and raw conversion result
  typedef struct packed {
    logic        action;
    logic [23:0] raw_sample;
  } in_item_t;

  // result item
  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] temperature_centi;
    logic signed [23:0] pressure_pa;
  } out_item_t;

  // request to the shift-add multiplier
  typedef struct packed {
    logic       start;
    logic [4:0] steps;
  } mul_req_t;

  // sample kinds
  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_PRES = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_SENS     = 3'd0;
  localparam logic [2:0] REG_OFFSET   = 3'd1;
  localparam logic [2:0] REG_TCS      = 3'd2;
  localparam logic [2:0] REG_TCO      = 3'd3;
  localparam logic [2:0] REG_TREF     = 3'd4;
  localparam logic [2:0] REG_TEMPSENS = 3'd5;

  // compensation constants
  localparam logic signed [19:0] TEMP_BASE = 20'sd2000;
  localparam logic signed [19:0] TEMP_LOW  = -20'sd1500;

  // multiplier operand widths in bit steps
  localparam logic [4:0] STEPS_CAL  = 5'd17;
  localparam logic [4:0] STEPS_DT   = 5'd26;
  localparam logic [4:0] STEPS_TDIF = 5'd20;
  localparam logic [4:0] STEPS_RAW  = 5'd25;

endpackage

// ===== rtl/baro_temp_pressure_compensation_core.sv =====
// Barometric sensor compensation, second-order scheme.
// Input channel (in_valid_i/in_ready_o, in_item_i): one raw 24-bit conversion
// result per item, tagged temperature (action 0) or pressure (action 1).
// Output channel (out_valid_o/out_ready_i, out_item_o): one result per item.
// Config channel (cfg_valid_i/cfg_ready_o): cfg_index_i selects one of six
// calibration words, cfg_data_i is written; unknown indexes are dropped.
// All products come from one shift-add multiplier, one multiplier bit per
// cycle, so latency from acceptance to out_valid_o follows the operand widths:
//   pressure item: one product
//   temperature item: three products, plus squarings below 20.00 degrees and
//   below -15.00 degrees (up to three extra squarings)
// One item is processed at a time; in_ready_o is high while idle.
// The result sits in an output register; the next item is taken while it
// waits, and a finished item holds in the last step until the slot frees.
// Reset clears calibration words, the stored offset and sensitivity, and
// all valid flags; a pressure item before any temperature item gives 0.
module baro_temp_pressure_compensation_core
  import btpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_FIXT  = 3'd3;
  localparam logic [2:0] ST_FIXP  = 3'd4;

  localparam logic [2:0] OP_TEMP = 3'd0;
  localparam logic [2:0] OP_OFF  = 3'd1;
  localparam logic [2:0] OP_SENS = 3'd2;
  localparam logic [2:0] OP_DT2  = 3'd3;
  localparam logic [2:0] OP_A    = 3'd4;
  localparam logic [2:0] OP_B    = 3'd5;
  localparam logic [2:0] OP_PRES = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] op_q, op_d;

  logic [15:0] c_sens_q, c_off_q, c_tcs_q, c_tco_q, c_tref_q, c_tsens_q;

  logic signed [63:0] off_acc_q, off_acc_d;
  logic signed [63:0] sens_acc_q, sens_acc_d;

  logic [23:0]        raw_q, raw_d;
  logic signed [25:0] dt_q, dt_d;
  logic signed [19:0] t_q, t_d;
  logic        [18:0] t2_q, t2_d;
  logic signed [63:0] off_q, off_d, sens_q, sens_d;
  logic signed [63:0] off2_q, off2_d, sens2_q, sens2_d;
  logic signed [63:0] p_q, p_d;

  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  mul_req_t           mreq;
  logic signed [63:0] mcand;
  logic signed [25:0] mplier;
  logic               mdone;
  logic signed [63:0] prod;

  logic signed [19:0] tdif;
  logic signed [63:0] five_a, seven_b, eleven_b;
  logic signed [20:0] tfin;
  logic signed [63:0] pshift;
  logic               slot_free;

  btpc_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mreq),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .done_o   (mdone),
    .product_o(prod)
  );

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_sens_q  <= 16'd0;
      c_off_q   <= 16'd0;
      c_tcs_q   <= 16'd0;
      c_tco_q   <= 16'd0;
      c_tref_q  <= 16'd0;
      c_tsens_q <= 16'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SENS:     c_sens_q  <= cfg_data_i;
        REG_OFFSET:   c_off_q   <= cfg_data_i;
        REG_TCS:      c_tcs_q   <= cfg_data_i;
        REG_TCO:      c_tco_q   <= cfg_data_i;
        REG_TREF:     c_tref_q  <= cfg_data_i;
        REG_TEMPSENS: c_tsens_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // multiplier operands per step
  always_comb begin
    tdif = (op_q == OP_B) ? (t_q - TEMP_LOW) : (t_q - TEMP_BASE);
    mcand  = 64'(dt_q);
    mplier = 26'(c_tsens_q);
    mreq.steps = STEPS_CAL;
    case (op_q)
      OP_OFF:  mplier = 26'(c_tco_q);
      OP_SENS: mplier = 26'(c_tcs_q);
      OP_DT2: begin
        mplier     = dt_q;
        mreq.steps = STEPS_DT;
      end
      OP_A, OP_B: begin
        mcand      = 64'(tdif);
        mplier     = 26'(tdif);
        mreq.steps = STEPS_TDIF;
      end
      OP_PRES: begin
        mcand      = sens_acc_q;
        mplier     = 26'(raw_q);
        mreq.steps = STEPS_RAW;
      end
      default: ;
    endcase
    mreq.start = (state_q == ST_ISSUE);
  end

  // constant multiples of the squares
  assign five_a   = (prod <<< 2) + prod;
  assign seven_b  = (prod <<< 3) - prod;
  assign eleven_b = (prod <<< 3) + (prod <<< 1) + prod;

  assign tfin   = 21'(t_q) - 21'(signed'({2'b00, t2_q}));
  assign pshift = p_q >>> 15;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    raw_d       = raw_q;
    dt_d        = dt_q;
    t_d         = t_q;
    t2_d        = t2_q;
    off_d       = off_q;
    sens_d      = sens_q;
    off2_d      = off2_q;
    sens2_d     = sens2_q;
    p_d         = p_q;
    off_acc_d   = off_acc_q;
    sens_acc_d  = sens_acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          raw_d   = in_item_i.raw_sample;
          dt_d    = signed'(26'(in_item_i.raw_sample)) - signed'(26'({c_tref_q, 8'h00}));
          t2_d    = 19'd0;
          off2_d  = 64'sd0;
          sens2_d = 64'sd0;
          op_d    = (in_item_i.action == KIND_PRES) ? OP_PRES : OP_TEMP;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mdone) begin
          state_d = ST_ISSUE;
          case (op_q)
            OP_TEMP: begin
              t_d  = TEMP_BASE + prod[42:23];
              op_d = OP_OFF;
            end
            OP_OFF: begin
              off_d = signed'({32'd0, c_off_q, 16'd0}) + (prod >>> 7);
              op_d  = OP_SENS;
            end
            OP_SENS: begin
              sens_d = signed'({33'd0, c_sens_q, 15'd0}) + (prod >>> 8);
              if (t_q < TEMP_BASE) begin
                op_d = OP_DT2;
              end else begin
                state_d = ST_FIXT;
              end
            end
            OP_DT2: begin
              t2_d = prod[49:31];
              op_d = OP_A;
            end
            OP_A: begin
              off2_d  = five_a >>> 1;
              sens2_d = five_a >>> 2;
              if (t_q < TEMP_LOW) begin
                op_d = OP_B;
              end else begin
                state_d = ST_FIXT;
              end
            end
            OP_B: begin
              off2_d  = off2_q + seven_b;
              sens2_d = sens2_q + (eleven_b >>> 1);
              state_d = ST_FIXT;
            end
            default: begin
              p_d     = (prod >>> 21) - off_acc_q;
              state_d = ST_FIXP;
            end
          endcase
        end
      end
      ST_FIXT: begin
        if (slot_free) begin
          off_acc_d   = off_q - off2_q;
          sens_acc_d  = sens_q - sens2_q;
          out_d.result_kind = KIND_TEMP;
          out_d.pressure_pa = 24'sd0;
          if (tfin > 21'sd32767) begin
            out_d.temperature_centi = 16'sh7fff;
          end else if (tfin < -21'sd32768) begin
            out_d.temperature_centi = 16'sh8000;
          end else begin
            out_d.temperature_centi = tfin[15:0];
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_FIXP: begin
        if (slot_free) begin
          out_d.result_kind       = KIND_PRES;
          out_d.temperature_centi = 16'sd0;
          if (pshift > 64'sd8388607) begin
            out_d.pressure_pa = 24'sh7fffff;
          end else if (pshift < -64'sd8388608) begin
            out_d.pressure_pa = 24'sh800000;
          end else begin
            out_d.pressure_pa = pshift[23:0];
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state and stored compensation values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_TEMP;
      out_valid_q <= 1'b0;
      off_acc_q   <= 64'sd0;
      sens_acc_q  <= 64'sd0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      off_acc_q   <= off_acc_d;
      sens_acc_q  <= sens_acc_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    raw_q   <= raw_d;
    dt_q    <= dt_d;
    t_q     <= t_d;
    t2_q    <= t2_d;
    off_q   <= off_d;
    sens_q  <= sens_d;
    off2_q  <= off2_d;
    sens2_q <= sens2_d;
    p_q     <= p_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/btpc_mul.sv =====
module btpc_mul
  import btpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mul_req_t           req_i,
  input  logic signed [63:0] mcand_i,
  input  logic signed [25:0] mplier_i,
  output logic               done_o,
  output logic signed [63:0] product_o
);

  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] mc_q, mc_d;
  logic        [25:0] mp_q, mp_d;
  logic        [4:0]  cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic signed [63:0] addend;
  logic               last;

  // one multiplier bit per cycle, top bit carries negative weight
  always_comb begin
    addend = mp_q[0] ? mc_q : 64'sd0;
    last   = (cnt_q == 5'd1);
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d  = 64'sd0;
      mc_d   = mcand_i;
      mp_d   = mplier_i;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = last ? (acc_q - addend) : (acc_q + addend);
      mc_d  = mc_q <<< 1;
      mp_d  = mp_q >> 1;
      cnt_d = cnt_q - 5'd1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule
